@@ sv/sorted_set_insert_delete_assert.svh @@
// Assertion macros for the sorted set block and its checker.
// Expects clk and arst_n in the scope of each use.
`ifndef SORTED_SET_INSERT_DELETE_ASSERT_SVH
`define SORTED_SET_INSERT_DELETE_ASSERT_SVH

// same-cycle implication
`define SSID_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SSID_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/ssid_pkg.sv @@
// Shared types and constants for the sorted set block.
// No dependencies.
package ssid_pkg;

	localparam int CAPACITY_DEF = 32;
	localparam int VALUE_W      = 32;
	localparam int COUNT_W      = 6;
	localparam int S_TDATA_W    = 32;
	localparam int M_TDATA_W    = 40;
	localparam int M_TUSER_W    = 3;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_DELETE = 1'b1;

	typedef enum logic [1:0] {
		ST_DONE,
		ST_DUP,
		ST_NOTFOUND,
		ST_FULL
	} ssid_status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_PASS,
		S_EMPTY
	} ssid_state_t;

	typedef struct packed {
		logic [COUNT_W-1:0]        count;
		logic signed [VALUE_W-1:0] element;
		logic                      has_element;
		ssid_status_t              status;
		logic                      last;
	} ssid_res_t;

endpackage

@@ sv/sorted_set_insert_delete.sv @@
// Top level of the sorted set block: request sequencer around the value RAM.
// Depends on ssid_pkg, ssid_ram, ssid_out_reg.
//
// Keeps up to CAPACITY distinct signed values in ascending order in one RAM
// with a single read port. A request takes one input transaction, then a
// binary search in which each probe passes through a read state and a
// compare state, then one pass that writes the shifted list back when the set
// changes and emits every stored value, one result per cycle while the output
// is taken, ending with tlast. An empty set gives one result with has_element
// low. A new request is accepted once the pass has been issued, while the
// last result may still wait in the output register.
module sorted_set_insert_delete import ssid_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // value
	input  logic [0:0]           s_tuser,  // req_type
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,  // count, element, zero pad
	output logic [M_TUSER_W-1:0] m_tuser,  // has_element, status
	output logic                 m_tlast
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	ssid_state_t state_q, state_d;

	logic                      op_q;
	logic signed [VALUE_W-1:0] val_q;
	logic [CW-1:0]             n_q;
	logic [CW-1:0]             cnt_q;
	logic [CW-1:0]             lo_q, hi_q;
	logic                      found_q;
	ssid_status_t              status_q;
	logic [CW-1:0]             j_q;
	logic                      s1_valid;
	logic [CW-1:0]             j_s1;
	logic [VALUE_W-1:0]        prev_q;

	logic [CW:0]        mid_sum;
	logic [CW-1:0]      mid;
	logic               srch_done;
	ssid_status_t       dec_status;
	logic [CW-1:0]      dec_n2;
	logic               ins, upd;
	logic               out_free, out_load;
	ssid_res_t          out_res;
	logic               s1_adv, issue_ok;
	logic [CW-1:0]      ra;
	logic               pass_re, srch_re;
	logic               ram_re, ram_we;
	logic [AW-1:0]      ram_raddr;
	logic [VALUE_W-1:0] ram_rdata;
	logic [VALUE_W-1:0] elem_s1;
	logic               last_s1;

	assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid       = mid_sum[CW:1];
	assign srch_done = !(lo_q < hi_q);
	assign ins       = (op_q == REQ_INSERT);
	assign upd       = (status_q == ST_DONE);

	always_comb begin
		dec_status = ST_DONE;
		dec_n2     = n_q;
		if (ins) begin
			if (found_q) begin
				dec_status = ST_DUP;
			end else if (n_q >= CAP_C) begin
				dec_status = ST_FULL;
			end else begin
				dec_n2 = n_q + CW'(1);
			end
		end else begin
			if (!found_q) begin
				dec_status = ST_NOTFOUND;
			end else begin
				dec_n2 = n_q - CW'(1);
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) state_d = S_SRCH_RD;
			end
			S_SRCH_RD: begin
				if (!srch_done)        state_d = S_SRCH_CMP;
				else if (dec_n2 == '0) state_d = S_EMPTY;
				else                   state_d = S_PASS;
			end
			S_SRCH_CMP: state_d = S_SRCH_RD;
			S_PASS: begin
				if (j_q == cnt_q && !s1_valid) state_d = S_IDLE;
			end
			S_EMPTY: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		s_tready = 1'b0;
		srch_re  = 1'b0;
		case (state_q)
			S_IDLE:    s_tready = 1'b1;
			S_SRCH_RD: srch_re  = !srch_done;
			default: begin
				s_tready = 1'b0;
				srch_re  = 1'b0;
			end
		endcase
	end

	assign s1_adv   = s1_valid && out_free;
	assign issue_ok = (state_q == S_PASS) && (j_q < cnt_q) && (!s1_valid || s1_adv);
	assign ra       = (!ins && upd && j_q >= lo_q) ? j_q + CW'(1) : j_q;
	assign pass_re  = issue_ok && (ra < n_q);

	assign ram_re    = srch_re || pass_re;
	assign ram_raddr = (state_q == S_PASS) ? ra[AW-1:0] : mid[AW-1:0];

	always_comb begin
		elem_s1 = ram_rdata;
		if (upd && ins) begin
			if (j_s1 == lo_q)     elem_s1 = val_q;
			else if (j_s1 > lo_q) elem_s1 = prev_q;
		end
	end

	assign last_s1 = (({1'b0, j_s1} + (CW+1)'(1)) == {1'b0, cnt_q});
	assign ram_we  = s1_adv && upd && (j_s1 >= lo_q);

	always_comb begin
		out_res.count  = COUNT_W'(cnt_q);
		out_res.status = status_q;
		if (state_q == S_EMPTY) begin
			out_res.element     = '0;
			out_res.has_element = 1'b0;
			out_res.last        = 1'b1;
		end else begin
			out_res.element     = elem_s1;
			out_res.has_element = 1'b1;
			out_res.last        = last_s1;
		end
	end

	assign out_load = s1_adv || (state_q == S_EMPTY && out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			s1_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_SRCH_RD && srch_done) begin
				cnt_q <= dec_n2;
			end
			if (issue_ok) begin
				s1_valid <= 1'b1;
			end else if (s1_adv) begin
				s1_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					op_q    <= s_tuser[0];
					val_q   <= s_tdata;
					n_q     <= cnt_q;
					lo_q    <= '0;
					hi_q    <= cnt_q;
					found_q <= 1'b0;
				end
			end
			S_SRCH_RD: begin
				if (srch_done) begin
					status_q <= dec_status;
					j_q      <= '0;
				end
			end
			S_SRCH_CMP: begin
				if ($signed(ram_rdata) < val_q) begin
					lo_q <= mid + CW'(1);
				end else begin
					hi_q <= mid;
				end
				if ($signed(ram_rdata) == val_q) begin
					found_q <= 1'b1;
				end
			end
			S_PASS: begin
				if (issue_ok) begin
					j_q  <= j_q + CW'(1);
					j_s1 <= j_q;
				end
				if (s1_adv) begin
					prev_q <= ram_rdata;
				end
			end
			default: begin
			end
		endcase
	end

	ssid_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (j_s1[AW-1:0]),
		.wdata (elem_s1),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	ssid_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (out_load),
		.res      (out_res),
		.free     (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

@@ sv/ssid_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ssid_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ sv/ssid_out_reg.sv @@
// Output register for the result stream; packs results onto the master port.
// Depends on ssid_pkg.
module ssid_out_reg import ssid_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  ssid_res_t            res,
	output logic                 free,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,  // count, element, zero pad
	output logic [M_TUSER_W-1:0] m_tuser,  // has_element, status
	output logic                 m_tlast
);

	logic      valid_q;
	ssid_res_t res_q;

	assign free = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			res_q <= res;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {(M_TDATA_W - VALUE_W - COUNT_W)'(0), res_q.element, res_q.count};
	assign m_tuser  = {res_q.status, res_q.has_element};
	assign m_tlast  = res_q.last;

endmodule

@@ sv/ssid_checker.sv @@
// Port-level checker for the sorted set block, bound to the top level.
// Depends on ssid_pkg and sorted_set_insert_delete_assert.svh.
`include "sorted_set_insert_delete_assert.svh"

module ssid_checker import ssid_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic [M_TUSER_W-1:0] m_tuser,
	input logic                 m_tlast
);

	logic                      out_acc;
	logic                      run_q;
	logic signed [VALUE_W-1:0] prev_elem_q;
	logic [COUNT_W-1:0]        prev_count_q;
	logic [1:0]                prev_status_q;

	assign out_acc = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q         <= 1'b0;
			prev_elem_q   <= '0;
			prev_count_q  <= '0;
			prev_status_q <= '0;
		end else if (out_acc) begin
			run_q         <= !m_tlast;
			prev_elem_q   <= m_tdata[37:6];
			prev_count_q  <= m_tdata[5:0];
			prev_status_q <= m_tuser[2:1];
		end
	end

	`SSID_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast),
		"result changed while stalled")

	`SSID_ASSERT_NOW(a_empty_form, m_tvalid && !m_tuser[0],
		m_tlast && m_tdata[37:6] == '0 && m_tdata[5:0] == '0,
		"empty-set result malformed")

	`SSID_ASSERT_NOW(a_ascending, out_acc && run_q,
		$signed(m_tdata[37:6]) > prev_elem_q,
		"elements not strictly ascending")

	`SSID_ASSERT_NOW(a_run_const, out_acc && run_q,
		m_tdata[5:0] == prev_count_q && m_tuser[2:1] == prev_status_q && m_tuser[0],
		"count or status changed within a run")

endmodule

bind sorted_set_insert_delete ssid_checker u_chk (.*);
